@@ rtl/core/rxr_pkg.sv @@
// ----------------------------------------------------------------------------
// rxr_pkg: shared constants, types and helpers
// Constants of the splitmix64 and xorshift64* steps, register indexes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rxr_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [DATA_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [DATA_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;
  localparam logic [DATA_W-1:0] STAR_MUL     = 64'h2545f4914f6cdd1d;
  // splitmix64 of a zero seed
  localparam logic [DATA_W-1:0] SEED0_STATE  = 64'he220a8397b1dcdaf;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 2'd2;

  // multiplier operand selects
  localparam logic [1:0] MSEL_MIX_A = 2'd0;
  localparam logic [1:0] MSEL_MIX_B = 2'd1;
  localparam logic [1:0] MSEL_STAR  = 2'd2;

  // divider dividend selects
  localparam logic DSEL_DRAW  = 1'b0;
  localparam logic DSEL_LIMIT = 1'b1;

  typedef struct packed {
    logic       load_mix;   // work <= seed + gamma
    logic       mul_go;
    logic [1:0] mul_sel;
    logic       take_prod;  // work <= product
    logic       mix_done;   // state <= finalised mix
    logic       step;       // state <= xorshift(state)
    logic       div_go;
    logic       div_sel;
    logic       take_rem;   // work <= remainder + low bound
    logic       set_range;
    logic       set_limit;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic state_zero;
    logic full_range;
    logic reject;
  } dp_stat_t;

  function automatic logic [DATA_W-1:0] xs_step(input logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage

@@ rtl/core/rxr_if.sv @@
// ----------------------------------------------------------------------------
// rxr channel interfaces
// Valid/ready channels for draw requests and for random values.
// ----------------------------------------------------------------------------
interface rxr_req_if;
  logic valid;
  logic ready;
  logic request;
  modport source (output valid, output request, input ready);
  modport sink (input valid, input request, output ready);
endinterface

interface rxr_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ rtl/core/rxr_mul.sv @@
// ----------------------------------------------------------------------------
// rxr_mul: sequential 64x64 multiplier, low half
// One 32x32 partial product a cycle: low by low, low by high, high by low.
// ----------------------------------------------------------------------------
module rxr_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [rxr_pkg::DATA_W-1:0] a,
  input  logic [rxr_pkg::DATA_W-1:0] b,
  output logic                 done,
  output logic [rxr_pkg::DATA_W-1:0] prod
);
  import rxr_pkg::*;

  localparam int unsigned HW = DATA_W / 2;
  localparam logic [1:0] LastStep = 2'd2;

  logic [DATA_W-1:0] a_q, b_q;
  logic [1:0]        step;
  logic              busy;
  logic [HW-1:0]     op_x, op_y;
  logic [DATA_W-1:0] pp;

  always_comb begin
    case (step)
      2'd0: begin
        op_x = a_q[HW-1:0];
        op_y = b_q[HW-1:0];
      end
      2'd1: begin
        op_x = a_q[HW-1:0];
        op_y = b_q[DATA_W-1:HW];
      end
      default: begin
        op_x = a_q[DATA_W-1:HW];
        op_y = b_q[HW-1:0];
      end
    endcase
    pp = DATA_W'(op_x) * DATA_W'(op_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == LastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
    end
    if (busy) begin
      if (step == 2'd0) prod <= pp;
      else prod <= prod + {pp[HW-1:0], {HW{1'b0}}};
    end
  end

endmodule

@@ rtl/core/rxr_div.sv @@
// ----------------------------------------------------------------------------
// rxr_div: restoring remainder unit
// One dividend bit a cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rxr_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [rxr_pkg::DATA_W-1:0] num,
  input  logic [rxr_pkg::DATA_W-1:0] den,
  output logic                 done,
  output logic [rxr_pkg::DATA_W-1:0] rem
);
  import rxr_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_W);

  logic [DATA_W-1:0] num_q, den_q;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic [DATA_W:0]   trial;
  logic              ge;

  assign trial = {rem, num_q[DATA_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= num;
      den_q <= den;
      rem   <= '0;
    end else if (busy) begin
      num_q <= num_q << 1;
      if (ge) rem <= trial[DATA_W-1:0] - den_q;
      else rem <= trial[DATA_W-1:0];
    end
  end

endmodule

@@ rtl/core/rxr_datapath.sv @@
// ----------------------------------------------------------------------------
// rxr_datapath: generator state, range registers and arithmetic
// Holds configuration and state, runs the multiplier and remainder units.
// ----------------------------------------------------------------------------
module rxr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rxr_pkg::DATA_W-1:0]    cfg_data,
  input  rxr_pkg::dp_cmd_t              cmd,
  output rxr_pkg::dp_stat_t             stat,
  output logic [rxr_pkg::DATA_W-1:0]    out_value
);
  import rxr_pkg::*;

  logic [DATA_W-1:0] seed_value, range_low, range_high;
  logic [DATA_W-1:0] gen_state, span_m1, accept_limit, low_bound;
  logic [DATA_W-1:0] work;
  logic [DATA_W-1:0] mul_a, mul_b, prod;
  logic [DATA_W-1:0] div_num, rem;
  logic              mul_done, div_done;
  logic              swap;

  always_comb begin
    case (cmd.mul_sel)
      MSEL_MIX_A: begin
        mul_a = work ^ (work >> 30);
        mul_b = MIX_MUL_A;
      end
      MSEL_MIX_B: begin
        mul_a = prod ^ (prod >> 27);
        mul_b = MIX_MUL_B;
      end
      default: begin
        mul_a = xs_step(gen_state);
        mul_b = STAR_MUL;
      end
    endcase
  end

  assign div_num = (cmd.div_sel == DSEL_LIMIT) ? ~span_m1 : prod;
  assign swap    = range_low > range_high;

  rxr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  rxr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (span_m1 + 64'd1),
    .done  (div_done),
    .rem   (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value   <= '0;
      range_low    <= '0;
      range_high   <= '1;
      gen_state    <= SEED0_STATE;
      span_m1      <= '1;
      accept_limit <= '0;
      low_bound    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SEED: seed_value <= cfg_data;
          REG_LOW:  range_low  <= cfg_data;
          REG_HIGH: range_high <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.mix_done) gen_state <= prod ^ (prod >> 31);
      else if (cmd.step) gen_state <= xs_step(gen_state);
      if (cmd.set_range) begin
        low_bound <= swap ? range_high : range_low;
        span_m1   <= swap ? range_low - range_high : range_high - range_low;
      end
      // limit is 2^64 minus (2^64 mod span), wrapping to zero
      if (cmd.set_limit) accept_limit <= (&span_m1) ? '0 : '0 - rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mix) work <= seed_value + GOLDEN_GAMMA;
    else if (cmd.take_prod) work <= prod;
    else if (cmd.take_rem) work <= rem + low_bound;
    if (cmd.load_out) out_value <= work;
  end

  assign stat.mul_done   = mul_done;
  assign stat.div_done   = div_done;
  assign stat.state_zero = gen_state == '0;
  assign stat.full_range = &span_m1;
  assign stat.reject     = (accept_limit != '0) && (prod >= accept_limit);

endmodule

@@ rtl/core/rxr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxr_ctrl: sequencing state machine
// Orders seeding, range set-up and draws, and owns the handshakes.
// ----------------------------------------------------------------------------
module rxr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          req_valid,
  input  logic                          req_request,
  output logic                          req_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  input  rxr_pkg::dp_stat_t             stat,
  output rxr_pkg::dp_cmd_t              cmd
);
  import rxr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MIX0  = 4'd1;
  localparam logic [3:0] S_MIX1  = 4'd2;
  localparam logic [3:0] S_MIX2  = 4'd3;
  localparam logic [3:0] S_RLIM  = 4'd4;
  localparam logic [3:0] S_RWAIT = 4'd5;
  localparam logic [3:0] S_DRAW  = 4'd6;
  localparam logic [3:0] S_DMUL  = 4'd7;
  localparam logic [3:0] S_DDIV  = 4'd8;
  localparam logic [3:0] S_DOUT  = 4'd9;

  logic [3:0] state, state_next;
  logic       seed_pend, range_pend, ret_draw;
  logic       ret_draw_next, seed_clr, range_clr;
  logic       out_free;

  assign req_ready = (state == S_IDLE) && !seed_pend && !range_pend;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MSEL_STAR;
    cmd.div_sel   = DSEL_DRAW;
    state_next    = state;
    ret_draw_next = ret_draw;
    seed_clr      = 1'b0;
    range_clr     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (seed_pend) begin
          seed_clr      = 1'b1;
          cmd.load_mix  = 1'b1;
          ret_draw_next = 1'b0;
          state_next    = S_MIX0;
        end else if (range_pend) begin
          range_clr     = 1'b1;
          cmd.set_range = 1'b1;
          state_next    = S_RLIM;
        end else if (req_valid && req_request) begin
          state_next = S_DRAW;
        end
      end
      S_MIX0: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_MIX_A;
        state_next  = S_MIX1;
      end
      S_MIX1: begin
        if (stat.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MSEL_MIX_B;
          state_next  = S_MIX2;
        end
      end
      S_MIX2: begin
        if (stat.mul_done) begin
          cmd.mix_done = 1'b1;
          state_next   = ret_draw ? S_DRAW : S_IDLE;
        end
      end
      S_RLIM: begin
        if (stat.full_range) begin
          cmd.set_limit = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DSEL_LIMIT;
          state_next  = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (stat.div_done) begin
          cmd.set_limit = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DRAW: begin
        // a freshly reseeded state is stepped even if the mix gave zero
        if (stat.state_zero && !ret_draw) begin
          cmd.load_mix  = 1'b1;
          ret_draw_next = 1'b1;
          state_next    = S_MIX0;
        end else begin
          cmd.step      = 1'b1;
          cmd.mul_go    = 1'b1;
          cmd.mul_sel   = MSEL_STAR;
          ret_draw_next = 1'b0;
          state_next    = S_DMUL;
        end
      end
      S_DMUL: begin
        if (stat.mul_done) begin
          if (stat.full_range) begin
            cmd.take_prod = 1'b1;
            state_next    = S_DOUT;
          end else if (stat.reject) begin
            state_next = S_DRAW;
          end else begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DSEL_DRAW;
            state_next  = S_DDIV;
          end
        end
      end
      S_DDIV: begin
        if (stat.div_done) begin
          cmd.take_rem = 1'b1;
          state_next   = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seed_pend  <= 1'b0;
      range_pend <= 1'b0;
      ret_draw   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      ret_draw <= ret_draw_next;
      seed_pend  <= (cfg_wr_en && cfg_index == REG_SEED) || (seed_pend && !seed_clr);
      range_pend <= (cfg_wr_en && (cfg_index == REG_LOW || cfg_index == REG_HIGH))
                    || (range_pend && !range_clr);
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/ranged_xorshift_random.sv @@
// ----------------------------------------------------------------------------
// ranged_xorshift_random: ranged xorshift64* random number generator
// Uniform 64-bit draws within a configurable inclusive range.
// ----------------------------------------------------------------------------
// Each transfer with request set yields one value drawn uniformly from the
// inclusive range between range_low and range_high (reversed bounds are
// swapped); a transfer with request clear is consumed with no result. The
// generator is xorshift64* (shifts 12, 25, 27), seeded with splitmix64 of the
// seed register on a seed write, and again whenever the state reads zero.
// Draws that would bias the modulo are rejected and the generator steps
// again. The 64-bit product goes through one shared 32x32 multiplier, and
// the reduction by the span through a restoring remainder unit at one bit
// a cycle. A seed write keeps requests out while splitmix64 runs, and a
// bound write while the acceptance limit is worked out. A finished value
// waits in an output register, and the next request is taken while it
// waits.
module ranged_xorshift_random (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rxr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rxr_pkg::DATA_W-1:0]    cfg_data,
  rxr_req_if.sink                       req,
  rxr_res_if.source                     res
);
  import rxr_pkg::*;

  dp_cmd_t  cmd;   // controller to datapath
  dp_stat_t stat;  // datapath to controller

  // sequencing and handshakes
  rxr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .req_valid   (req.valid),
    .req_request (req.request),
    .req_ready   (req.ready),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  // registers, multiplier and remainder unit
  rxr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_value (res.value)
  );

endmodule
